@@ src/scp_pkg.sv @@
// Shared types and sequencer codes for the second-chance page replacer.
package scp_pkg;

	typedef logic [2:0] state_t;

	localparam state_t ST_IDLE   = 3'd0;
	localparam state_t ST_LOOKUP = 3'd1;
	localparam state_t ST_SCAN   = 3'd2;
	localparam state_t ST_SHIFT  = 3'd3;
	localparam state_t ST_DONE   = 3'd4;

endpackage

@@ src/scp_if.sv @@
// Valid/ready channel interfaces for page accesses and replacement results.
interface scp_in_if #(
	parameter int ADDR_BITS  = 52,
	parameter int OWNER_BITS = 8
);
	logic                  valid;
	logic                  ready;
	logic [ADDR_BITS-1:0]  page_address;
	logic [OWNER_BITS-1:0] owner_id;
	logic                  evict_request;

	modport source (output valid, page_address, owner_id, evict_request, input ready);
	modport sink   (input valid, page_address, owner_id, evict_request, output ready);
endinterface

interface scp_out_if #(
	parameter int ADDR_BITS  = 52,
	parameter int OWNER_BITS = 8
);
	logic                  valid;
	logic                  ready;
	logic [OWNER_BITS-1:0] result_owner;
	logic [ADDR_BITS-1:0]  result_address;
	logic                  evicted;
	logic                  was_hit;
	logic                  overflow;

	modport source (output valid, result_owner, result_address, evicted, was_hit, overflow,
		input ready);
	modport sink   (input valid, result_owner, result_address, evicted, was_hit, overflow,
		output ready);
endinterface

@@ src/scp_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module scp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ src/second_chance_page_replacer.sv @@
// Second-chance page replacer: age-ordered page table with referenced bits.
// Steps: accept, lookup, eviction scan, shift-down removal (one entry per cycle), and
// hand-off to the output register.
// One item at a time through the table RAM; hand-off waits while the previous word still
// waits in the output register, and the next access is taken only after hand-off.
// Reset clears the entry count and control state; table contents stay undefined, no sweep.
module second_chance_page_replacer #(
	parameter int NUM_ENTRIES = 64,
	parameter int ADDR_BITS   = 52,
	parameter int OWNER_BITS  = 8
) (
	input  logic      clk,
	input  logic      arst_n,
	scp_in_if.sink    acc,
	scp_out_if.source res
);
	import scp_pkg::*;

	localparam int IDX_W  = $clog2(NUM_ENTRIES);
	localparam int CNT_W  = $clog2(NUM_ENTRIES + 1);
	localparam int WORD_W = ADDR_BITS + OWNER_BITS + 1;
	localparam logic [CNT_W-1:0] FULL = CNT_W'(NUM_ENTRIES);

	state_t                state_q;
	logic [ADDR_BITS-1:0]  page_q;
	logic [OWNER_BITS-1:0] owner_q;
	logic                  evict_q;
	logic                  pend_new_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [CNT_W-1:0]      rd_idx_q;
	logic                  chk_v_q;
	logic [IDX_W-1:0]      chk_idx_q;
	logic [OWNER_BITS-1:0] r_owner_q;
	logic [ADDR_BITS-1:0]  r_addr_q;
	logic                  evicted_q;
	logic                  hit_q;
	logic                  ovf_q;

	logic                  o_vld_q;
	logic [OWNER_BITS-1:0] o_owner_q;
	logic [ADDR_BITS-1:0]  o_addr_q;
	logic                  o_evicted_q;
	logic                  o_hit_q;
	logic                  o_ovf_q;

	logic                  we;
	logic [IDX_W-1:0]      waddr;
	logic [WORD_W-1:0]     wdata;
	logic [IDX_W-1:0]      raddr;
	logic [WORD_W-1:0]     rdata;
	logic [ADDR_BITS-1:0]  rd_addr_f;
	logic [OWNER_BITS-1:0] rd_owner_f;
	logic                  rd_ref;
	logic                  issue_ok;
	logic                  match;
	logic [CNT_W-1:0]      cnt_m1;
	logic                  out_load;

	scp_ram #(
		.WIDTH (WORD_W),
		.DEPTH (NUM_ENTRIES)
	) u_table (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign rd_addr_f  = rdata[WORD_W-1 -: ADDR_BITS];
	assign rd_owner_f = rdata[1 +: OWNER_BITS];
	assign rd_ref     = rdata[0];
	assign raddr      = rd_idx_q[IDX_W-1:0];
	assign issue_ok   = rd_idx_q < cnt_q;
	assign match      = chk_v_q && (rd_addr_f == page_q);
	assign cnt_m1     = cnt_q - 1'b1;
	assign out_load   = (state_q == ST_DONE) && (!o_vld_q || res.ready);

	assign acc.ready          = (state_q == ST_IDLE);
	assign res.valid          = o_vld_q;
	assign res.result_owner   = o_owner_q;
	assign res.result_address = o_addr_q;
	assign res.evicted        = o_evicted_q;
	assign res.was_hit        = o_hit_q;
	assign res.overflow       = o_ovf_q;

	// table write port: reference update, append, or shift-down
	always_comb begin
		we    = 1'b0;
		waddr = chk_idx_q;
		wdata = {rd_addr_f, rd_owner_f, 1'b0};
		unique case (state_q)
			ST_LOOKUP: begin
				if (match) begin
					we    = 1'b1;
					wdata = {rd_addr_f, rd_owner_f, 1'b1};
				end else if (!issue_ok && (cnt_q < FULL)) begin
					we    = 1'b1;
					waddr = cnt_q[IDX_W-1:0];
					wdata = {page_q, owner_q, 1'b0};
				end
			end
			ST_SCAN: begin
				we = chk_v_q && rd_ref;
			end
			ST_SHIFT: begin
				if (chk_v_q) begin
					we    = 1'b1;
					waddr = chk_idx_q - 1'b1;
					wdata = rdata;
				end else if (!issue_ok && pend_new_q) begin
					we    = 1'b1;
					waddr = cnt_m1[IDX_W-1:0];
					wdata = {page_q, owner_q, 1'b0};
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			page_q     <= '0;
			owner_q    <= '0;
			evict_q    <= 1'b0;
			pend_new_q <= 1'b0;
			cnt_q      <= '0;
			rd_idx_q   <= '0;
			chk_v_q    <= 1'b0;
			chk_idx_q  <= '0;
			r_owner_q  <= '0;
			r_addr_q   <= '0;
			evicted_q  <= 1'b0;
			hit_q      <= 1'b0;
			ovf_q      <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (acc.valid) begin
						page_q     <= acc.page_address;
						owner_q    <= acc.owner_id;
						evict_q    <= acc.evict_request;
						r_owner_q  <= acc.owner_id;
						r_addr_q   <= acc.page_address;
						evicted_q  <= 1'b0;
						hit_q      <= 1'b0;
						ovf_q      <= 1'b0;
						pend_new_q <= 1'b0;
						rd_idx_q   <= '0;
						chk_v_q    <= 1'b0;
						state_q    <= ST_LOOKUP;
					end
				end
				ST_LOOKUP: begin
					if (match || !issue_ok) begin
						if (match) begin
							hit_q     <= 1'b1;
							r_owner_q <= rd_owner_f;
						end else if (cnt_q < FULL) begin
							cnt_q <= cnt_q + 1'b1;
						end else if (evict_q) begin
							pend_new_q <= 1'b1;
						end else begin
							ovf_q <= 1'b1;
						end
						rd_idx_q <= '0;
						chk_v_q  <= 1'b0;
						state_q  <= evict_q ? ST_SCAN : ST_DONE;
					end else begin
						chk_v_q   <= 1'b1;
						chk_idx_q <= rd_idx_q[IDX_W-1:0];
						rd_idx_q  <= rd_idx_q + 1'b1;
					end
				end
				ST_SCAN: begin
					// keep the oldest entry in hand in case every bit is set
					if (chk_v_q && (chk_idx_q == '0 || !rd_ref)) begin
						r_owner_q <= rd_owner_f;
						r_addr_q  <= rd_addr_f;
					end
					if (chk_v_q && !rd_ref) begin
						evicted_q <= 1'b1;
						rd_idx_q  <= CNT_W'(chk_idx_q) + 1'b1;
						chk_v_q   <= 1'b0;
						state_q   <= ST_SHIFT;
					end else if (!issue_ok) begin
						chk_v_q <= 1'b0;
						if (pend_new_q) begin
							// the new page is the victim and is never stored
							r_owner_q <= owner_q;
							r_addr_q  <= page_q;
							evicted_q <= 1'b1;
							state_q   <= ST_DONE;
						end else if (cnt_q != '0) begin
							evicted_q <= 1'b1;
							rd_idx_q  <= CNT_W'(1);
							state_q   <= ST_SHIFT;
						end else begin
							state_q <= ST_DONE;
						end
					end else begin
						chk_v_q   <= 1'b1;
						chk_idx_q <= rd_idx_q[IDX_W-1:0];
						rd_idx_q  <= rd_idx_q + 1'b1;
					end
				end
				ST_SHIFT: begin
					if (issue_ok) begin
						chk_v_q   <= 1'b1;
						chk_idx_q <= rd_idx_q[IDX_W-1:0];
						rd_idx_q  <= rd_idx_q + 1'b1;
					end else begin
						chk_v_q <= 1'b0;
						if (!chk_v_q) begin
							// the pending page takes the freed newest slot
							if (!pend_new_q) begin
								cnt_q <= cnt_m1;
							end
							state_q <= ST_DONE;
						end
					end
				end
				ST_DONE: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			o_vld_q     <= 1'b0;
			o_owner_q   <= '0;
			o_addr_q    <= '0;
			o_evicted_q <= 1'b0;
			o_hit_q     <= 1'b0;
			o_ovf_q     <= 1'b0;
		end else if (out_load) begin
			o_vld_q     <= 1'b1;
			o_owner_q   <= r_owner_q;
			o_addr_q    <= r_addr_q;
			o_evicted_q <= evicted_q;
			o_hit_q     <= hit_q;
			o_ovf_q     <= ovf_q;
		end else if (res.ready) begin
			o_vld_q <= 1'b0;
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= FULL)
		else $error("entry count above table depth");

	a_cnt_step: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == $past(cnt_q)) || (cnt_q == $past(cnt_q) + 1'b1) ||
		(cnt_q + 1'b1 == $past(cnt_q)))
		else $error("entry count moved by more than one");

	a_shift_idx: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SHIFT && chk_v_q) |-> (chk_idx_q != '0))
		else $error("shift write below slot zero");

	a_flags: assert property (@(posedge clk) disable iff (!arst_n)
		o_vld_q |-> !(o_ovf_q && (o_evicted_q || o_hit_q)))
		else $error("overflow together with hit or eviction");

endmodule
